// File: src/assert_macros.svh
// Assertion macros shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tracker assertion failed");

// Check a property on the module's own clk_i and rst_ni.
`define ASSERT_STD(lbl, prop) `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: src/pret_pkg.sv
// Types, constants and scaling factors of the pen report event tracker.
package pret_pkg;

  // Raw status codes of a report
  localparam logic [7:0] StatusOut    = 8'h00;
  localparam logic [7:0] StatusIn     = 8'h10;
  localparam logic [7:0] StatusTip    = 8'h11;
  localparam logic [7:0] StatusBarrel = 8'h12;
  localparam logic [7:0] StatusRight  = 8'h13;

  // Mode bytes below this value carry no report
  localparam logic [7:0] ModeMin = 8'd2;

  // Configuration
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned ViewW      = 12;
  localparam logic [ViewW-1:0] ViewMaxReset = 12'd1023;
  localparam logic [CfgAddrW-1:0] RegViewXMax = 3'd0;
  localparam logic [CfgAddrW-1:0] RegViewYMax = 3'd4;

  // Field widths
  localparam int unsigned RawW   = 16;
  localparam int unsigned PosW   = 15;
  localparam int unsigned PressW = 14;
  localparam int unsigned ProdW  = RawW + ViewW;

  // Queue depth between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // X span 14000 = 16 * 875: drop 4 bits, then exact reciprocal of 875
  localparam int unsigned XPre    = 4;
  localparam int unsigned XDiv    = 14000 / (1 << XPre);
  localparam int unsigned XDivW   = ProdW - XPre;
  localparam int unsigned XShift  = XDivW + 10;
  localparam longint unsigned RecipXFull = ((64'd1 << XShift) + XDiv - 1) / XDiv;
  localparam int unsigned RecipXW = 25;
  localparam logic [RecipXW-1:0] RecipX = RecipXW'(RecipXFull);
  localparam int unsigned XMulW   = XDivW + RecipXW;

  // Y span 8200 = 8 * 1025: drop 3 bits, then exact reciprocal of 1025
  localparam int unsigned YPre    = 3;
  localparam int unsigned YDiv    = 8200 / (1 << YPre);
  localparam int unsigned YDivW   = ProdW - YPre;
  localparam int unsigned YShift  = YDivW + 11;
  localparam longint unsigned RecipYFull = ((64'd1 << YShift) + YDiv - 1) / YDiv;
  localparam int unsigned RecipYW = 27;
  localparam logic [RecipYW-1:0] RecipY = RecipYW'(RecipYFull);
  localparam int unsigned YMulW   = YDivW + RecipYW;

  // Status class after decode
  typedef enum logic [2:0] {
    ClsOut,
    ClsIn,
    ClsTip,
    ClsBarrel,
    ClsRight,
    ClsOther
  } pret_class_e;

  // Event codes on the result port
  typedef enum logic [2:0] {
    EvTouch   = 3'd0,
    EvRelease = 3'd1,
    EvMenu    = 3'd2,
    EvHome    = 3'd3,
    EvBack    = 3'd4
  } pret_event_e;

  // Classified report handed from front to back
  typedef struct packed {
    pret_class_e          cls;
    logic [PosW-1:0]      x_pos;
    logic [PosW-1:0]      y_pos;
    logic [PressW-1:0]    pressure;
    logic                 press_nz;
  } pret_item_t;

  // Map a raw status byte to its class
  function automatic pret_class_e classify(input logic [7:0] status);
    pret_class_e cls;
    case (status)
      StatusOut:    cls = ClsOut;
      StatusIn:     cls = ClsIn;
      StatusTip:    cls = ClsTip;
      StatusBarrel: cls = ClsBarrel;
      StatusRight:  cls = ClsRight;
      default:      cls = ClsOther;
    endcase
    return cls;
  endfunction

endpackage

// File: src/pen_report_event_tracker.sv
// A report passes the first scaling stage, the second scaling stage, the queue write and the back stage
// for the pen state, each registered, before its event shows on the result ports.
// Throughput: one report per cycle while nothing stalls, set by the pen state update in the back end.
// A queue of QueueDepth reports between front and back absorbs result-side stalls.
// Reset clears all pen state and queues and sets both view registers to 1023; no clearing pass.
// Reports with mode byte 0 or 1 are taken and dropped in the front end.
module pen_report_event_tracker #(
  parameter int unsigned QueueDepth = pret_pkg::QueueDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Report input
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     mode_byte_i,
  input  logic [7:0]                     pen_status_i,
  input  logic [pret_pkg::RawW-1:0]      x_raw_i,
  input  logic [pret_pkg::RawW-1:0]      y_raw_i,
  input  logic [pret_pkg::RawW-1:0]      pressure_raw_i,
  // Event output
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     event_kind_o,
  output logic [pret_pkg::PosW-1:0]      x_pos_o,
  output logic [pret_pkg::PosW-1:0]      y_pos_o,
  output logic [pret_pkg::PressW-1:0]    pressure_out_o,
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pret_pkg::CfgAddrW-1:0]  paddr,
  input  logic [pret_pkg::CfgDataW-1:0]  pwdata,
  output logic [pret_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import pret_pkg::*;

  logic [ViewW-1:0] view_x_max_q;
  logic [ViewW-1:0] view_y_max_q;
  logic             cfg_write;
  logic             in_ready;
  logic             front_valid;
  pret_item_t       front_item;
  logic             q_full;
  logic             q_empty;
  logic             q_rd;
  pret_item_t       q_item;
  logic             out_valid;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_x_max_q <= ViewMaxReset;
      view_y_max_q <= ViewMaxReset;
    end else if (cfg_write) begin
      if (paddr[2] == RegViewYMax[2]) begin
        view_y_max_q <= pwdata[ViewW-1:0];
      end else begin
        view_x_max_q <= pwdata[ViewW-1:0];
      end
    end
  end

  // Return the addressed register
  assign prdata = (paddr[2] == RegViewYMax[2]) ? CfgDataW'(view_y_max_q)
                                               : CfgDataW'(view_x_max_q);

  pret_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (push),
    .in_ready_o     (in_ready),
    .mode_byte_i    (mode_byte_i),
    .pen_status_i   (pen_status_i),
    .x_raw_i        (x_raw_i),
    .y_raw_i        (y_raw_i),
    .pressure_raw_i (pressure_raw_i),
    .view_x_max_i   (view_x_max_q),
    .view_y_max_i   (view_y_max_q),
    .out_valid_o    (front_valid),
    .out_ready_i    (!q_full),
    .item_o         (front_item)
  );

  pret_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid && !q_full),
    .wr_data_i (front_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_item),
    .empty_o   (q_empty)
  );

  pret_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (!q_empty),
    .item_i       (q_item),
    .rd_o         (q_rd),
    .out_valid_o  (out_valid),
    .out_pop_i    (pop),
    .event_kind_o (event_kind_o),
    .x_pos_o      (x_pos_o),
    .y_pos_o      (y_pos_o),
    .pressure_o   (pressure_out_o)
  );

  assign full  = !in_ready;
  assign empty = !out_valid;

endmodule

// File: src/pret_front.sv
// Front end: accepts reports, drops idle ones, classifies and scales.
module pret_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  mode_byte_i,
  input  logic [7:0]                  pen_status_i,
  input  logic [pret_pkg::RawW-1:0]   x_raw_i,
  input  logic [pret_pkg::RawW-1:0]   y_raw_i,
  input  logic [pret_pkg::RawW-1:0]   pressure_raw_i,
  input  logic [pret_pkg::ViewW-1:0]  view_x_max_i,
  input  logic [pret_pkg::ViewW-1:0]  view_y_max_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pret_pkg::pret_item_t        item_o
);
  import pret_pkg::*;

  // Stage one: classify and multiply by the view size
  logic              s1_valid_q;
  pret_class_e       s1_cls_q;
  logic [ProdW-1:0]  s1_xprod_q;
  logic [ProdW-1:0]  s1_yprod_q;
  logic [PressW-1:0] s1_press_q;
  logic              s1_nz_q;

  // Stage two: divide by the spans through reciprocal multiply
  logic              s2_valid_q;
  pret_item_t        s2_item_q;

  logic              s1_ready;
  logic              s2_ready;
  logic [XMulW-1:0]  x_mul;
  logic [YMulW-1:0]  y_mul;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i && (mode_byte_i >= ModeMin);
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Load stage one payload
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_cls_q   <= classify(pen_status_i);
      s1_xprod_q <= ProdW'(x_raw_i) * ProdW'(view_x_max_i);
      s1_yprod_q <= ProdW'(y_raw_i) * ProdW'(view_y_max_i);
      s1_press_q <= pressure_raw_i[RawW-1:2];
      s1_nz_q    <= |pressure_raw_i;
    end
  end

  assign x_mul = XMulW'(s1_xprod_q[ProdW-1:XPre]) * XMulW'(RecipX);
  assign y_mul = YMulW'(s1_yprod_q[ProdW-1:YPre]) * YMulW'(RecipY);

  // Load stage two payload
  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_item_q.cls      <= s1_cls_q;
      s2_item_q.x_pos    <= x_mul[XShift +: PosW];
      s2_item_q.y_pos    <= y_mul[YShift +: PosW];
      s2_item_q.pressure <= s1_press_q;
      s2_item_q.press_nz <= s1_nz_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign item_o      = s2_item_q;

endmodule

// File: src/pret_fifo.sv
// Short queue of classified reports between front and back.
`include "assert_macros.svh"

module pret_fifo #(
  parameter int unsigned Depth = pret_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  pret_pkg::pret_item_t wr_data_i,
  output logic                 full_o,
  input  logic                 rd_i,
  output pret_pkg::pret_item_t rd_data_o,
  output logic                 empty_o
);
  import pret_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pret_item_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Step a pointer with wrap at the depth
  function automatic logic [PtrW-1:0] step_ptr(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= step_ptr(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= step_ptr(rd_ptr_q);
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store a written entry
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `ASSERT_STD(no_write_when_full, wr_i |-> !full_o)
  `ASSERT_STD(no_read_when_empty, rd_i |-> !empty_o)
  `ASSERT_STD(count_tracks_write, (wr_i && !rd_i) |=> (count_q == $past(count_q) + 1'b1))

endmodule

// File: src/pret_back.sv
// Back end: pen state tracking and event output register.
`include "assert_macros.svh"

module pret_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          avail_i,
  input  pret_pkg::pret_item_t          item_i,
  output logic                          rd_o,
  output logic                          out_valid_o,
  input  logic                          out_pop_i,
  output logic [2:0]                    event_kind_o,
  output logic [pret_pkg::PosW-1:0]     x_pos_o,
  output logic [pret_pkg::PosW-1:0]     y_pos_o,
  output logic [pret_pkg::PressW-1:0]   pressure_o
);
  import pret_pkg::*;

  // Pen state
  pret_class_e     prev_cls_q, prev_cls_d;
  logic            prev_valid_q, prev_valid_d;
  logic            prev_pzero_q, prev_pzero_d;
  logic            touch_q, touch_d;
  logic [PosW-1:0] saved_x_q, saved_x_d;
  logic [PosW-1:0] saved_y_q, saved_y_d;
  logic            menu_q, menu_d;
  logic            home_q, home_d;
  logic            back_q, back_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  pret_event_e       out_kind_q;
  logic [PosW-1:0]   out_x_q;
  logic [PosW-1:0]   out_y_q;
  logic [PressW-1:0] out_p_q;

  logic        advance;
  logic        ev_valid;
  pret_event_e ev_kind;
  logic        prev_in;
  logic        prev_right;

  assign advance    = avail_i && (!out_valid_q || out_pop_i);
  assign rd_o       = advance;
  assign prev_in    = prev_valid_q && (prev_cls_q == ClsIn);
  assign prev_right = prev_valid_q && (prev_cls_q == ClsRight);

  // Decide the event and the next pen state
  always_comb begin
    ev_valid     = 1'b0;
    ev_kind      = EvTouch;
    prev_cls_d   = item_i.cls;
    prev_valid_d = 1'b1;
    prev_pzero_d = !item_i.press_nz;
    touch_d      = touch_q;
    saved_x_d    = saved_x_q;
    saved_y_d    = saved_y_q;
    menu_d       = menu_q;
    home_d       = home_q;
    back_d       = back_q;
    case (item_i.cls)
      ClsOut: begin
        if (menu_q) begin
          ev_valid = 1'b1; ev_kind = EvMenu; menu_d = 1'b0;
        end else if (home_q) begin
          ev_valid = 1'b1; ev_kind = EvHome; home_d = 1'b0;
        end else if (back_q) begin
          ev_valid = 1'b1; ev_kind = EvBack; back_d = 1'b0;
        end else if (touch_q) begin
          ev_valid = 1'b1; ev_kind = EvRelease; touch_d = 1'b0;
        end
      end
      ClsIn: begin
        if (menu_q) begin
          ev_valid = 1'b1; ev_kind = EvMenu; menu_d = 1'b0;
        end else if (back_q) begin
          ev_valid = 1'b1; ev_kind = EvBack; back_d = 1'b0;
        end else if (touch_q) begin
          ev_valid = 1'b1; ev_kind = EvRelease; touch_d = 1'b0;
        end
      end
      ClsTip: begin
        if ((item_i.x_pos != saved_x_q) && (item_i.y_pos != saved_y_q)) begin
          ev_valid  = 1'b1;
          ev_kind   = EvTouch;
          saved_x_d = item_i.x_pos;
          saved_y_d = item_i.y_pos;
          touch_d   = 1'b1;
        end
      end
      ClsBarrel: begin
        if (prev_in) begin
          menu_d = 1'b1;
        end
      end
      ClsRight: begin
        if (home_q) begin
          ev_valid = 1'b1; ev_kind = EvHome; home_d = 1'b0;
        end else if (prev_in) begin
          back_d = 1'b1;
        end else if (prev_right && prev_pzero_q && item_i.press_nz) begin
          home_d = 1'b1;
          back_d = 1'b0;
        end
      end
      default: begin
        ev_valid = 1'b0;
      end
    endcase
  end

  // Hold the output until popped, reload on advance
  always_comb begin
    if (advance) begin
      out_valid_d = ev_valid;
    end else begin
      out_valid_d = out_valid_q && !out_pop_i;
    end
  end

  // Update pen state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cls_q   <= ClsOut;
      prev_valid_q <= 1'b0;
      prev_pzero_q <= 1'b0;
      touch_q      <= 1'b0;
      saved_x_q    <= '0;
      saved_y_q    <= '0;
      menu_q       <= 1'b0;
      home_q       <= 1'b0;
      back_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        prev_cls_q   <= prev_cls_d;
        prev_valid_q <= prev_valid_d;
        prev_pzero_q <= prev_pzero_d;
        touch_q      <= touch_d;
        saved_x_q    <= saved_x_d;
        saved_y_q    <= saved_y_d;
        menu_q       <= menu_d;
        home_q       <= home_d;
        back_q       <= back_d;
      end
    end
  end

  // Load the event payload
  always_ff @(posedge clk_i) begin
    if (advance && ev_valid) begin
      out_kind_q <= ev_kind;
      if (ev_kind == EvTouch) begin
        out_x_q <= item_i.x_pos;
        out_y_q <= item_i.y_pos;
        out_p_q <= item_i.pressure;
      end else begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_p_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign x_pos_o      = out_x_q;
  assign y_pos_o      = out_y_q;
  assign pressure_o   = out_p_q;

  `ASSERT_STD(home_back_exclusive, !(home_q && back_q))
  `ASSERT_STD(touch_sets_active, (advance && ev_valid && ev_kind == EvTouch) |=> touch_q)
  `ASSERT_STD(read_only_when_free, rd_o |-> (!out_valid_q || out_pop_i))

endmodule

// File: test/testbench.sv
// Self-checking testbench for the pen report event tracker: directed and random report streams.
`timescale 1ns / 100ps

module testbench;
  import pret_pkg::*;

  localparam int unsigned XSpan       = 14000;
  localparam int unsigned YSpan       = 8200;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomPerSet = 150;

  // One event as seen on the result ports
  typedef struct {
    pret_event_e           kind;
    logic [PosW-1:0]       x_pos;
    logic [PosW-1:0]       y_pos;
    logic [PressW-1:0]     pressure;
  } pen_event_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            mode_byte_i = '0;
  logic [7:0]            pen_status_i = '0;
  logic [RawW-1:0]       x_raw_i = '0;
  logic [RawW-1:0]       y_raw_i = '0;
  logic [RawW-1:0]       pressure_raw_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [2:0]            event_kind_o;
  logic [PosW-1:0]       x_pos_o;
  logic [PosW-1:0]       y_pos_o;
  logic [PressW-1:0]     pressure_out_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CfgAddrW-1:0]   paddr = '0;
  logic [CfgDataW-1:0]   pwdata = '0;
  logic [CfgDataW-1:0]   prdata;
  logic                  pready;

  // Predictor copy of the view size and pen state
  logic [ViewW-1:0]      scale_x = ViewMaxReset;
  logic [ViewW-1:0]      scale_y = ViewMaxReset;
  logic [7:0]            prior_status = '0;
  logic                  prior_status_ok = 1'b0;
  logic [RawW-1:0]       prior_pressure = '0;
  logic                  prior_pressure_ok = 1'b0;
  logic                  pen_down = 1'b0;
  logic [PosW-1:0]       touch_x = '0;
  logic [PosW-1:0]       touch_y = '0;
  logic                  menu_due = 1'b0;
  logic                  home_due = 1'b0;
  logic                  back_due = 1'b0;

  pen_event_t            pending_events[$];
  int unsigned           mismatches = 0;
  int unsigned           reports_taken = 0;
  int unsigned           cycle_count = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;

  pen_report_event_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_byte_i    (mode_byte_i),
    .pen_status_i   (pen_status_i),
    .x_raw_i        (x_raw_i),
    .y_raw_i        (y_raw_i),
    .pressure_raw_i (pressure_raw_i),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind_o),
    .x_pos_o        (x_pos_o),
    .y_pos_o        (y_pos_o),
    .pressure_out_o (pressure_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("pen_report_event_tracker: mismatch");
      $finish;
    end
  end

  // Queue one expected event
  function automatic void expect_event(input pret_event_e kind, input logic [PosW-1:0] x,
                                       input logic [PosW-1:0] y, input logic [PressW-1:0] p);
    pen_event_t ev;
    ev.kind = kind;
    ev.x_pos = x;
    ev.y_pos = y;
    ev.pressure = p;
    pending_events.push_back(ev);
  endfunction

  // Advance the pen state for one accepted report and queue its event, if any
  function automatic void predict_pen_event(input logic [7:0] mode, input logic [7:0] status,
                                            input logic [RawW-1:0] x_raw,
                                            input logic [RawW-1:0] y_raw,
                                            input logic [RawW-1:0] press);
    logic [7:0]      was_status;
    logic            was_status_ok;
    logic [RawW-1:0] was_pressure;
    logic            was_pressure_ok;
    int unsigned     xs;
    int unsigned     ys;
    if (mode < ModeMin) return;
    was_status = prior_status;
    was_status_ok = prior_status_ok;
    was_pressure = prior_pressure;
    was_pressure_ok = prior_pressure_ok;
    prior_status = status;
    prior_status_ok = 1'b1;
    prior_pressure = press;
    prior_pressure_ok = 1'b1;
    xs = (int'(x_raw) * int'(scale_x)) / XSpan;
    ys = (int'(y_raw) * int'(scale_y)) / YSpan;
    case (status)
      StatusOut: begin
        if (menu_due) begin
          menu_due = 1'b0;
          expect_event(EvMenu, '0, '0, '0);
        end else if (home_due) begin
          home_due = 1'b0;
          expect_event(EvHome, '0, '0, '0);
        end else if (back_due) begin
          back_due = 1'b0;
          expect_event(EvBack, '0, '0, '0);
        end else if (pen_down) begin
          pen_down = 1'b0;
          expect_event(EvRelease, '0, '0, '0);
        end
      end
      StatusIn: begin
        if (menu_due) begin
          menu_due = 1'b0;
          expect_event(EvMenu, '0, '0, '0);
        end else if (back_due) begin
          back_due = 1'b0;
          expect_event(EvBack, '0, '0, '0);
        end else if (pen_down) begin
          pen_down = 1'b0;
          expect_event(EvRelease, '0, '0, '0);
        end
      end
      StatusTip: begin
        // touch only when the position moved on both axes
        if (xs != touch_x && ys != touch_y) begin
          touch_x = xs[PosW-1:0];
          touch_y = ys[PosW-1:0];
          pen_down = 1'b1;
          expect_event(EvTouch, xs[PosW-1:0], ys[PosW-1:0], press[RawW-1:2]);
        end
      end
      StatusBarrel: begin
        if (was_status_ok && was_status == StatusIn) menu_due = 1'b1;
      end
      StatusRight: begin
        if (home_due) begin
          home_due = 1'b0;
          expect_event(EvHome, '0, '0, '0);
        end else if (was_status_ok && was_status == StatusIn) begin
          back_due = 1'b1;
        end else if (was_status_ok && was_status == StatusRight) begin
          // rising pressure on a held right button arms home
          if (was_pressure_ok && was_pressure == '0 && press != '0) begin
            home_due = 1'b1;
            back_due = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Drain side: check each transfer against the oldest expectation, then pick the next pop
  always @(posedge clk_i) begin : event_drain
    pen_event_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_events.size() == 0) begin
        $error("event_kind: expected none, actual %0d", event_kind_o);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, event_kind_o);
          mismatches++;
        end
        if (x_pos_o !== want.x_pos) begin
          $error("x_pos: expected %0d, actual %0d", want.x_pos, x_pos_o);
          mismatches++;
        end
        if (y_pos_o !== want.y_pos) begin
          $error("y_pos: expected %0d, actual %0d", want.y_pos, y_pos_o);
          mismatches++;
        end
        if (pressure_out_o !== want.pressure) begin
          $error("pressure_out: expected %0d, actual %0d", want.pressure, pressure_out_o);
          mismatches++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one report and hold it until the block takes it
  task automatic send_report(input logic [7:0] mode, input logic [7:0] status,
                             input logic [RawW-1:0] x, input logic [RawW-1:0] y,
                             input logic [RawW-1:0] press);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    mode_byte_i <= mode;
    pen_status_i <= status;
    x_raw_i <= x;
    y_raw_i <= y;
    pressure_raw_i <= press;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_pen_event(mode, status, x, y, press);
    if (mode >= ModeMin) reports_taken++;
  endtask

  // Send a report with a random valid mode byte
  task automatic send_pen(input logic [7:0] status, input logic [RawW-1:0] x,
                          input logic [RawW-1:0] y, input logic [RawW-1:0] press);
    send_report(8'($urandom_range(255, ModeMin)), status, x, y, press);
  endtask

  // Wait until every event is out and the pipeline has settled
  task automatic wait_for_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_view_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegViewXMax) scale_x = value[ViewW-1:0];
    else if (addr == RegViewYMax) scale_y = value[ViewW-1:0];
    @(posedge clk_i);
  endtask

  task automatic check_view_reg(input logic [CfgAddrW-1:0] addr, input string name,
                                input logic [ViewW-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== CfgDataW'(want)) begin
      $error("%s: expected %0d, actual %0d", name, want, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Change the view size while idle and read it back
  task automatic set_view(input logic [CfgDataW-1:0] x_max, input logic [CfgDataW-1:0] y_max);
    wait_for_idle();
    write_view_reg(RegViewXMax, x_max);
    write_view_reg(RegViewYMax, y_max);
    check_view_reg(RegViewXMax, "view_x_max", scale_x);
    check_view_reg(RegViewYMax, "view_y_max", scale_y);
  endtask

  task automatic test_reset_values();
    check_view_reg(RegViewXMax, "view_x_max", ViewMaxReset);
    check_view_reg(RegViewYMax, "view_y_max", ViewMaxReset);
  endtask

  // Walk every status, the ignored mode bytes and the button sequences by hand
  task automatic test_directed_events();
    send_report(8'd0, StatusTip, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_report(8'd1, StatusTip, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_report(ModeMin, StatusOut, '0, '0, '0);
    send_report(8'hFF, StatusIn, '0, '0, '0);
    send_pen(StatusTip, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pen(StatusTip, 16'hFFFF, 16'hFFFF, 16'h1234);
    send_pen(StatusTip, 16'h0000, 16'hFFFF, 16'h0040);
    send_pen(StatusTip, 16'h0000, 16'h0000, 16'h0000);
    send_pen(StatusIn, '0, '0, '0);
    send_pen(StatusBarrel, '0, '0, '0);
    send_pen(StatusOut, '0, '0, '0);
    send_pen(StatusBarrel, '0, '0, '0);
    send_pen(StatusIn, '0, '0, '0);
    send_pen(StatusRight, '0, '0, 16'h0010);
    send_pen(StatusIn, '0, '0, '0);
    send_pen(StatusRight, '0, '0, '0);
    send_pen(StatusRight, '0, '0, '0);
    send_pen(StatusRight, '0, '0, 16'hFFFF);
    send_pen(StatusRight, '0, '0, '0);
    send_pen(StatusRight, '0, '0, 16'h0001);
    send_pen(StatusOut, '0, '0, '0);
    send_pen(8'h55, 16'h5555, 16'hAAAA, 16'h5555);
    send_pen(8'hFF, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_pen(StatusTip, 16'h8000, 16'h4000, 16'hFFFC);
    send_pen(StatusOut, '0, '0, '0);
  endtask

  // Strokes at the scaling extremes, including values with bits above the register width
  task automatic test_scaling_extremes();
    int unsigned i;
    set_view(32'd0, 32'd0);
    for (i = 0; i < 6; i++) send_pen(StatusTip, 16'($urandom_range(65535)),
                                     16'($urandom_range(65535)),
                                     16'($urandom_range(65535)));
    send_pen(StatusOut, '0, '0, '0);
    set_view(32'hFFFF_FFFF, 32'hFFFF_F000);
    for (i = 0; i < 6; i++) send_pen(StatusTip, 16'($urandom_range(65535)),
                                     16'($urandom_range(65535)),
                                     16'($urandom_range(65535)));
    send_pen(StatusIn, '0, '0, '0);
    set_view(32'd4095, 32'd4095);
    send_pen(StatusTip, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pen(StatusTip, 16'h0001, 16'h0001, 16'h0003);
    send_pen(StatusOut, '0, '0, '0);
  endtask

  // Random pen sessions: mostly well-formed strokes and button sequences, some noise
  task automatic test_random_sessions(input int unsigned count);
    int unsigned start;
    int unsigned k;
    logic [RawW-1:0] rx;
    logic [RawW-1:0] ry;
    start = reports_taken;
    while (reports_taken - start < count) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          send_pen(StatusIn, 16'($urandom_range(65535)), 16'($urandom_range(65535)), '0);
          rx = 16'($urandom_range(65535));
          ry = 16'($urandom_range(65535));
          for (k = $urandom_range(6, 1); k > 0; k--) begin
            // hold the position now and then so no touch goes out
            if ($urandom_range(3) != 0) begin
              rx = ($urandom_range(1) != 0) ? 16'($urandom_range(65535)) : rx;
              ry = 16'($urandom_range(65535));
            end
            send_pen(StatusTip, rx, ry, 16'($urandom_range(65535)));
          end
          send_pen($urandom_range(1) ? StatusIn : StatusOut, 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)));
        end
        3: begin
          send_pen(StatusIn, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
          for (k = $urandom_range(2, 1); k > 0; k--)
            send_pen(StatusBarrel, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
          send_pen($urandom_range(1) ? StatusIn : StatusOut, '0, '0,
                   16'($urandom_range(65535)));
        end
        4: begin
          send_pen(StatusIn, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
          send_pen(StatusRight, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
          send_pen($urandom_range(1) ? StatusIn : StatusOut, '0, '0, '0);
        end
        5: begin
          if ($urandom_range(1)) send_pen(StatusIn, '0, '0, 16'($urandom_range(65535)));
          send_pen(StatusRight, 16'($urandom_range(65535)), 16'($urandom_range(65535)), '0);
          send_pen(StatusRight, 16'($urandom_range(65535)), 16'($urandom_range(65535)), '0);
          send_pen(StatusRight, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535, 1)));
          case ($urandom_range(2))
            0: send_pen(StatusRight, '0, '0, 16'($urandom_range(65535)));
            1: send_pen(StatusOut, '0, '0, 16'($urandom_range(65535)));
            default: send_pen(StatusIn, '0, '0, 16'($urandom_range(65535)));
          endcase
        end
        6: begin
          send_pen($urandom_range(1) ? StatusIn : StatusOut, 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)));
        end
        default: begin
          // noise: any status byte, any mode byte
          for (k = $urandom_range(4, 1); k > 0; k--)
            send_report($urandom_range(3) == 0 ? 8'($urandom_range(1)) : 8'($urandom_range(255)),
                        ($urandom_range(1) != 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(StatusRight, StatusIn)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535)));
        end
      endcase
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned set_idx;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    send_idle_pct = 24;
    recv_idle_pct = 49;
    test_directed_events();
    test_scaling_extremes();

    // Random sessions under three idle patterns and several view sizes each
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (set_idx = 0; set_idx < 3; set_idx++) begin
        case (set_idx)
          0: set_view($urandom(), $urandom());
          1: set_view((phase == 1) ? 32'd0 : 32'd4095, (phase == 2) ? 32'd0 : 32'd4095);
          default: set_view($urandom_range(4095), $urandom_range(4095));
        endcase
        test_random_sessions(RandomPerSet);
      end
    end

    wait_for_idle();
    if (mismatches == 0) begin
      $display("pen_report_event_tracker: match");
    end else begin
      $display("pen_report_event_tracker: mismatch");
    end
    $finish;
  end

endmodule
